// ===== rtl/bech32_string_encoder_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Bech32 string encoder assertion macros
// Clocked concurrent assertion wrappers; ASSERT_OFF compiles them away.
// ---------------------------------------------------------------------------
`ifndef BECH32_STRING_ENCODER_UNIT_DEFINES_SVH
`define BECH32_STRING_ENCODER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// assertion disabled while reset is high
`define B32E_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion checked on every edge
`define B32E_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define B32E_ASSERT(lbl, clk, rst, prop, msg)
`define B32E_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== rtl/b32enc_pkg.sv =====
// ---------------------------------------------------------------------------
// Bech32 string encoder package
// Shared widths, codes, sequencer states, polymod constants and charset.
// ---------------------------------------------------------------------------
package b32enc_pkg;

   // field widths
   localparam int MODE_W      = 2;
   localparam int CHAR_W      = 8;
   localparam int SYM_W       = 5;
   localparam int POLY_W      = 30;
   localparam int OUT_LIMIT_W = 11;
   localparam int LEN_W       = 11;
   // wide enough for any length sum and for STRING_CAP
   localparam int CMP_W       = 13;
   localparam int STEP_W      = 3;

   // default sizes
   localparam int PART_MAX_DEF   = 128;
   localparam int STRING_CAP_DEF = 1024;

   localparam logic [OUT_LIMIT_W-1:0] OUT_LIMIT_RST = 11'd1024;

   // separator, empty status char and terminal checksum step
   localparam logic [CHAR_W-1:0] CHAR_SEP   = 8'h31;
   localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;
   localparam logic [STEP_W-1:0] CHECK_LAST = 3'd5;

   // polymod generators
   localparam logic [POLY_W-1:0] GEN0 = 30'h3b6a57b2;
   localparam logic [POLY_W-1:0] GEN1 = 30'h26508e6d;
   localparam logic [POLY_W-1:0] GEN2 = 30'h1ea119fa;
   localparam logic [POLY_W-1:0] GEN3 = 30'h3d4233dd;
   localparam logic [POLY_W-1:0] GEN4 = 30'h2a1462b3;
   localparam logic [POLY_W-1:0] POLY_INIT = 30'd1;

   // charset, first letter in the top byte
   localparam logic [32*CHAR_W-1:0] CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

   typedef enum logic [MODE_W-1:0] {
      MODE_PART = 2'd0,
      MODE_DATA = 2'd1,
      MODE_FIN  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_BAD_VALUE = 2'd1,
      STAT_TOO_LONG  = 2'd2,
      STAT_PART_FULL = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_SEP,
      ST_DATA,
      ST_ZERO,
      ST_FLIP,
      ST_CHK
   } state_type;

   typedef enum logic [2:0] {
      PU_HOLD,
      PU_INIT,
      PU_FEED,
      PU_FLIP,
      PU_SHIFT
   } poly_op_type;

   // command word from the sequencer to the polymod unit
   typedef struct packed {
      poly_op_type            op;
      logic [SYM_W-1:0]       sym;
   } poly_ctl_type;

   function automatic logic [CHAR_W-1:0] letter(input logic [SYM_W-1:0] sym);
      logic [SYM_W-1:0] pos;
      logic [7:0]       base;
      pos  = 5'd31 - sym;
      base = {pos, 3'b000};
      return CHARSET[base +: CHAR_W];
   endfunction

endpackage

// ===== rtl/b32enc_if.sv =====
// ---------------------------------------------------------------------------
// Bech32 string encoder channels
// Valid/ready channels for input items and emitted characters.
// ---------------------------------------------------------------------------
interface b32enc_req_if;
   logic                             valid;
   logic                             ready;
   logic [b32enc_pkg::MODE_W-1:0]    mode;
   logic [b32enc_pkg::CHAR_W-1:0]    value;

   modport source (output valid, mode, value, input ready);
   modport sink   (input valid, mode, value, output ready);
endinterface

interface b32enc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [b32enc_pkg::CHAR_W-1:0]    out_char;
   logic                             last;
   logic [1:0]                       status;

   modport source (output valid, out_char, last, status, input ready);
   modport sink   (input valid, out_char, last, status, output ready);
endinterface

// ===== rtl/b32enc_ram.sv =====
// ---------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle, registered read data.
// ---------------------------------------------------------------------------
module b32enc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wdata,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // storage and read register
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/b32enc_poly_unit.sv =====
// ---------------------------------------------------------------------------
// Bech32 polymod unit
// Holds the 30-bit checksum register; one feed, flip, shift or init per cycle, as ctl selects.
// ---------------------------------------------------------------------------
module b32enc_poly_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  b32enc_pkg::poly_ctl_type        ctl,
   output logic [b32enc_pkg::POLY_W-1:0]   poly
);

   logic [b32enc_pkg::POLY_W-1:0] poly_ff;
   logic [b32enc_pkg::POLY_W-1:0] poly_in;
   logic [b32enc_pkg::POLY_W-1:0] feed_val;
   logic [b32enc_pkg::SYM_W-1:0]  top;

   // one polymod step: shift in a symbol, fold the top five bits back
   always_comb begin
      top      = poly_ff[29:25];
      feed_val = {poly_ff[24:0], ctl.sym};
      if (top[0]) feed_val = feed_val ^ b32enc_pkg::GEN0;
      if (top[1]) feed_val = feed_val ^ b32enc_pkg::GEN1;
      if (top[2]) feed_val = feed_val ^ b32enc_pkg::GEN2;
      if (top[3]) feed_val = feed_val ^ b32enc_pkg::GEN3;
      if (top[4]) feed_val = feed_val ^ b32enc_pkg::GEN4;
   end

   // operation select
   always_comb begin
      unique case (ctl.op)
         b32enc_pkg::PU_HOLD:  poly_in = poly_ff;
         b32enc_pkg::PU_INIT:  poly_in = b32enc_pkg::POLY_INIT;
         b32enc_pkg::PU_FEED:  poly_in = feed_val;
         b32enc_pkg::PU_FLIP:  poly_in = poly_ff ^ b32enc_pkg::POLY_INIT;
         b32enc_pkg::PU_SHIFT: poly_in = {poly_ff[24:0], 5'd0};
         default:              poly_in = poly_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff <= b32enc_pkg::POLY_INIT;
      end else begin
         poly_ff <= poly_in;
      end
   end

   assign poly = poly_ff;

endmodule

// ===== rtl/bech32_string_encoder_unit.sv =====
// ---------------------------------------------------------------------------
// Bech32 string encoder
// Streams a Bech32 string with its checksum from part bytes and data values.
// ---------------------------------------------------------------------------
// Usage:
//   req_chan takes one word per item: mode (part byte, data value, finish)
//   and value. rsp_chan gives one word per character: out_char, last on the
//   final word of a string, status nonzero on a failed string's one word.
//   csr_we/csr_wdata write the output capacity (out_limit) while idle.
// Sequencing:
//   A part byte is taken in ST_IDLE; its echo is registered in the output
//   register. The first data value first walks the P part bytes out of the
//   part store RAM (one read per cycle, one polymod step per cycle), then
//   emits the separator and its letter. A finish (walk and separator first if
//   no data value came) feeds six zeros, flips, and emits six checksum letters.
// Reset:
//   Synchronous, active high: string state cleared, polymod register to 1,
//   out_limit to 1024. The part store is not cleared.
// Stall:
//   Each character waits in the output register; the states that emit one hold
//   while it is full and not taken, and req_chan.ready stays low meanwhile.
// ---------------------------------------------------------------------------
`include "bech32_string_encoder_unit_defines.svh"

module bech32_string_encoder_unit #(
   parameter int PART_MAX   = b32enc_pkg::PART_MAX_DEF,
   parameter int STRING_CAP = b32enc_pkg::STRING_CAP_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   b32enc_req_if.sink                            req_chan,
   b32enc_rsp_if.source                          rsp_chan,
   input  logic                                  csr_we,
   input  logic [b32enc_pkg::OUT_LIMIT_W-1:0]    csr_wdata
);

   localparam int PCNT_W = $clog2(PART_MAX + 1);
   localparam int ADDR_W = (PART_MAX > 1) ? $clog2(PART_MAX) : 1;
   localparam logic [b32enc_pkg::CMP_W-1:0] CAP_V    = b32enc_pkg::CMP_W'(STRING_CAP);
   localparam logic [PCNT_W-1:0]            PART_TOP = PCNT_W'(PART_MAX);

   // sequencer and string state
   b32enc_pkg::state_type                   state_ff, state_in;
   b32enc_pkg::status_type                  err_ff, err_in;
   logic                                    phase_ff, phase_in;
   logic [PCNT_W-1:0]                       part_cnt_ff, part_cnt_in;
   logic [PCNT_W-1:0]                       idx_ff, idx_in;
   logic [b32enc_pkg::LEN_W-1:0]            len_ff, len_in;
   logic                                    rd_pend_ff, rd_pend_in;
   logic [b32enc_pkg::SYM_W-1:0]            data_ff, data_in;
   logic                                    fin_ff, fin_in;
   logic [b32enc_pkg::STEP_W-1:0]           step_ff, step_in;
   logic [b32enc_pkg::OUT_LIMIT_W-1:0]      out_limit_ff;

   // output register
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic [b32enc_pkg::CHAR_W-1:0]           rsp_char_ff, rsp_char_in;
   logic                                    rsp_last_ff, rsp_last_in;
   b32enc_pkg::status_type                  rsp_status_ff, rsp_status_in;

   // datapath links
   b32enc_pkg::poly_ctl_type                pctl;
   logic [b32enc_pkg::POLY_W-1:0]           poly;
   logic                                    ram_we;
   logic [ADDR_W-1:0]                       ram_addr;
   logic [b32enc_pkg::CHAR_W-1:0]           ram_rdata;

   logic                                    out_free;
   logic                                    req_fire;
   logic [b32enc_pkg::CMP_W-1:0]            olim;
   logic [b32enc_pkg::CMP_W-1:0]            lim_now;
   logic [b32enc_pkg::CMP_W-1:0]            extra;
   logic                                    part_len_bad;
   logic                                    data_len_bad;
   logic                                    fin_len_bad;

   // part store
   b32enc_ram #(
      .WIDTH (b32enc_pkg::CHAR_W),
      .DEPTH (PART_MAX)
   ) u_part_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (req_chan.value),
      .rdata (ram_rdata)
   );

   // shared polymod unit
   b32enc_poly_unit u_poly (
      .clock (clock),
      .reset (reset),
      .ctl   (pctl),
      .poly  (poly)
   );

   // length limits against min(out_limit, STRING_CAP)
   always_comb begin
      olim         = b32enc_pkg::CMP_W'(out_limit_ff);
      lim_now      = (olim < CAP_V) ? olim : CAP_V;
      extra        = phase_ff ? '0 : b32enc_pkg::CMP_W'(1);
      part_len_bad = (b32enc_pkg::CMP_W'(part_cnt_ff) + b32enc_pkg::CMP_W'(9)) > lim_now;
      data_len_bad = (b32enc_pkg::CMP_W'(len_ff) + extra + b32enc_pkg::CMP_W'(8)) > lim_now;
      fin_len_bad  = (b32enc_pkg::CMP_W'(len_ff) + extra + b32enc_pkg::CMP_W'(7)) > lim_now;
   end

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == b32enc_pkg::ST_IDLE) && out_free;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // next state and outputs
   always_comb begin
      state_in      = state_ff;
      err_in        = err_ff;
      phase_in      = phase_ff;
      part_cnt_in   = part_cnt_ff;
      idx_in        = idx_ff;
      len_in        = len_ff;
      rd_pend_in    = rd_pend_ff;
      data_in       = data_ff;
      fin_in        = fin_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_char_in   = rsp_char_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      pctl.op       = b32enc_pkg::PU_HOLD;
      pctl.sym      = '0;
      ram_we        = 1'b0;
      ram_addr      = idx_ff[ADDR_W-1:0];

      unique case (state_ff)
         b32enc_pkg::ST_IDLE: begin
            if (req_fire) begin
               unique case (req_chan.mode)
                  b32enc_pkg::MODE_PART: begin
                     if (err_ff == b32enc_pkg::STAT_OK && !phase_ff) begin
                        if (part_len_bad) begin
                           err_in = b32enc_pkg::STAT_TOO_LONG;
                        end else if (part_cnt_ff >= PART_TOP) begin
                           err_in = b32enc_pkg::STAT_PART_FULL;
                        end else begin
                           ram_we        = 1'b1;
                           ram_addr      = part_cnt_ff[ADDR_W-1:0];
                           part_cnt_in   = part_cnt_ff + PCNT_W'(1);
                           len_in        = len_ff + b32enc_pkg::LEN_W'(1);
                           pctl.op       = b32enc_pkg::PU_FEED;
                           pctl.sym      = {2'b00, req_chan.value[7:5]};
                           rsp_valid_in  = 1'b1;
                           rsp_char_in   = req_chan.value;
                           rsp_last_in   = 1'b0;
                           rsp_status_in = b32enc_pkg::STAT_OK;
                        end
                     end
                  end
                  b32enc_pkg::MODE_DATA: begin
                     if (err_ff == b32enc_pkg::STAT_OK) begin
                        if (data_len_bad) begin
                           err_in = b32enc_pkg::STAT_TOO_LONG;
                        end else if (req_chan.value[7:5] != 3'd0) begin
                           err_in = b32enc_pkg::STAT_BAD_VALUE;
                        end else if (!phase_ff) begin
                           // open the data part: feed zero, walk the store
                           data_in    = req_chan.value[4:0];
                           fin_in     = 1'b0;
                           idx_in     = '0;
                           rd_pend_in = 1'b0;
                           pctl.op    = b32enc_pkg::PU_FEED;
                           state_in   = b32enc_pkg::ST_WALK;
                        end else begin
                           pctl.op       = b32enc_pkg::PU_FEED;
                           pctl.sym      = req_chan.value[4:0];
                           len_in        = len_ff + b32enc_pkg::LEN_W'(1);
                           rsp_valid_in  = 1'b1;
                           rsp_char_in   = b32enc_pkg::letter(req_chan.value[4:0]);
                           rsp_last_in   = 1'b0;
                           rsp_status_in = b32enc_pkg::STAT_OK;
                        end
                     end
                  end
                  b32enc_pkg::MODE_FIN: begin
                     if (err_ff != b32enc_pkg::STAT_OK || fin_len_bad) begin
                        // failed string: one status word, then clear
                        rsp_valid_in  = 1'b1;
                        rsp_char_in   = b32enc_pkg::CHAR_NONE;
                        rsp_last_in   = 1'b1;
                        rsp_status_in = (err_ff != b32enc_pkg::STAT_OK) ?
                                        err_ff : b32enc_pkg::STAT_TOO_LONG;
                        part_cnt_in   = '0;
                        len_in        = '0;
                        phase_in      = 1'b0;
                        err_in        = b32enc_pkg::STAT_OK;
                        pctl.op       = b32enc_pkg::PU_INIT;
                     end else if (!phase_ff) begin
                        fin_in     = 1'b1;
                        idx_in     = '0;
                        rd_pend_in = 1'b0;
                        pctl.op    = b32enc_pkg::PU_FEED;
                        state_in   = b32enc_pkg::ST_WALK;
                     end else begin
                        fin_in   = 1'b1;
                        step_in  = '0;
                        state_in = b32enc_pkg::ST_ZERO;
                     end
                  end
                  default: begin
                     // unused mode: ignored
                  end
               endcase
            end
         end

         b32enc_pkg::ST_WALK: begin
            // read one byte per cycle, feed the one read last cycle
            if (rd_pend_ff) begin
               pctl.op  = b32enc_pkg::PU_FEED;
               pctl.sym = ram_rdata[4:0];
            end
            if (idx_ff < part_cnt_ff) begin
               ram_addr   = idx_ff[ADDR_W-1:0];
               idx_in     = idx_ff + PCNT_W'(1);
               rd_pend_in = 1'b1;
            end else begin
               rd_pend_in = 1'b0;
               state_in   = b32enc_pkg::ST_SEP;
            end
         end

         b32enc_pkg::ST_SEP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_char_in   = b32enc_pkg::CHAR_SEP;
               rsp_last_in   = 1'b0;
               rsp_status_in = b32enc_pkg::STAT_OK;
               len_in        = len_ff + b32enc_pkg::LEN_W'(1);
               phase_in      = 1'b1;
               step_in       = '0;
               state_in      = fin_ff ? b32enc_pkg::ST_ZERO : b32enc_pkg::ST_DATA;
            end
         end

         b32enc_pkg::ST_DATA: begin
            if (out_free) begin
               pctl.op       = b32enc_pkg::PU_FEED;
               pctl.sym      = data_ff;
               len_in        = len_ff + b32enc_pkg::LEN_W'(1);
               rsp_valid_in  = 1'b1;
               rsp_char_in   = b32enc_pkg::letter(data_ff);
               rsp_last_in   = 1'b0;
               rsp_status_in = b32enc_pkg::STAT_OK;
               state_in      = b32enc_pkg::ST_IDLE;
            end
         end

         b32enc_pkg::ST_ZERO: begin
            // six zero feeds
            pctl.op = b32enc_pkg::PU_FEED;
            if (step_ff == b32enc_pkg::CHECK_LAST) begin
               state_in = b32enc_pkg::ST_FLIP;
            end else begin
               step_in = step_ff + b32enc_pkg::STEP_W'(1);
            end
         end

         b32enc_pkg::ST_FLIP: begin
            pctl.op  = b32enc_pkg::PU_FLIP;
            step_in  = '0;
            state_in = b32enc_pkg::ST_CHK;
         end

         b32enc_pkg::ST_CHK: begin
            // checksum letters from the top, shifting five bits a word
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_char_in   = b32enc_pkg::letter(poly[29:25]);
               rsp_status_in = b32enc_pkg::STAT_OK;
               if (step_ff == b32enc_pkg::CHECK_LAST) begin
                  rsp_last_in = 1'b1;
                  part_cnt_in = '0;
                  len_in      = '0;
                  phase_in    = 1'b0;
                  err_in      = b32enc_pkg::STAT_OK;
                  pctl.op     = b32enc_pkg::PU_INIT;
                  state_in    = b32enc_pkg::ST_IDLE;
               end else begin
                  rsp_last_in = 1'b0;
                  pctl.op     = b32enc_pkg::PU_SHIFT;
                  step_in     = step_ff + b32enc_pkg::STEP_W'(1);
               end
            end
         end

         default: begin
            state_in = b32enc_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= b32enc_pkg::ST_IDLE;
         err_ff       <= b32enc_pkg::STAT_OK;
         phase_ff     <= 1'b0;
         part_cnt_ff  <= '0;
         idx_ff       <= '0;
         len_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         fin_ff       <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         out_limit_ff <= b32enc_pkg::OUT_LIMIT_RST;
      end else begin
         state_ff     <= state_in;
         err_ff       <= err_in;
         phase_ff     <= phase_in;
         part_cnt_ff  <= part_cnt_in;
         idx_ff       <= idx_in;
         len_ff       <= len_in;
         rd_pend_ff   <= rd_pend_in;
         fin_ff       <= fin_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            out_limit_ff <= csr_wdata;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      data_ff       <= data_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_char = rsp_char_ff;
   assign rsp_chan.last     = rsp_last_ff;
   assign rsp_chan.status   = rsp_status_ff;

   // checks
   `B32E_ASSERT(a_status_word, clock, reset, (rsp_valid_ff && rsp_status_ff != b32enc_pkg::STAT_OK) |-> (rsp_last_ff && rsp_char_ff == b32enc_pkg::CHAR_NONE), "status word must be last with zero char")
   `B32E_ASSERT(a_part_bound, clock, reset, part_cnt_ff <= PART_TOP, "part count beyond store depth")
   `B32E_ASSERT(a_clear_after_chk, clock, reset, (state_ff == b32enc_pkg::ST_CHK && step_ff == b32enc_pkg::CHECK_LAST && out_free) |=> (part_cnt_ff == '0 && len_ff == '0 && !phase_ff && poly == b32enc_pkg::POLY_INIT), "string state not cleared after checksum")

endmodule

// ===== bench/tb_bech32_string_encoder_unit.sv =====
// ---------------------------------------------------------------------------
// Bech32 string encoder testbench
// Drives part bytes, data values and finish words into the encoder, predicts
// every emitted character with a cycle-free model of the BIP-173 checksum and
// compares each result word in order, under random stalls on both channels.
// ---------------------------------------------------------------------------
module tb_bech32_string_encoder_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PART_DEPTH  = 128;
   localparam int STR_CAP     = 1024;
   localparam int SETTLE      = 200;
   localparam int CYCLE_LIMIT = 800000;
   localparam int RAND_ITEMS  = 160;
   localparam int IDLE_PCT    = 35;

   localparam logic [b32enc_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

   // checksum generator terms
   localparam logic [29:0] POLY_G0 = 30'h3b6a57b2;
   localparam logic [29:0] POLY_G1 = 30'h26508e6d;
   localparam logic [29:0] POLY_G2 = 30'h1ea119fa;
   localparam logic [29:0] POLY_G3 = 30'h3d4233dd;
   localparam logic [29:0] POLY_G4 = 30'h2a1462b3;

   typedef struct packed {
      logic [7:0]             ch;
      logic                   last;
      b32enc_pkg::status_type st;
   } enc_word_type;

   // -------------------------------------------------------------------------
   // Scoreboard: string predictor plus queue of expected result words
   // -------------------------------------------------------------------------
   class bech32_scoreboard;
      enc_word_type           expected_words[$];
      logic [7:0]             part_bytes[PART_DEPTH];
      int unsigned            part_count;
      int unsigned            length_count;
      int unsigned            out_limit;
      logic [29:0]            poly;
      bit                     in_data;
      b32enc_pkg::status_type err;
      int                     mismatches;
      string                  charset;

      function new();
         charset    = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
         out_limit  = 1024;
         mismatches = 0;
         restart();
      endfunction

      function void restart();
         part_count   = 0;
         length_count = 0;
         poly         = 30'd1;
         in_data      = 1'b0;
         err          = b32enc_pkg::STAT_OK;
      endfunction

      function void set_limit(logic [b32enc_pkg::OUT_LIMIT_W-1:0] v);
         out_limit = v;
      endfunction

      function int unsigned cap();
         return (out_limit < STR_CAP) ? out_limit : STR_CAP;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      // one polymod step
      function void step(logic [4:0] sym);
         logic [4:0]  top;
         logic [29:0] c;
         top = poly[29:25];
         c = {poly[24:0], 5'b00000} ^ {25'd0, sym};
         if (top[0]) c ^= POLY_G0;
         if (top[1]) c ^= POLY_G1;
         if (top[2]) c ^= POLY_G2;
         if (top[3]) c ^= POLY_G3;
         if (top[4]) c ^= POLY_G4;
         poly = c;
      endfunction

      function void push(logic [7:0] ch, logic last, b32enc_pkg::status_type st);
         enc_word_type w;
         w.ch   = ch;
         w.last = last;
         w.st   = st;
         expected_words.push_back(w);
      endfunction

      // walk the stored part and emit the separator
      function void open_data();
         step(5'd0);
         for (int unsigned i = 0; i < part_count; i++) step(part_bytes[i][4:0]);
         in_data = 1'b1;
         length_count++;
         push("1", 1'b0, b32enc_pkg::STAT_OK);
      endfunction

      function void note_item(logic [b32enc_pkg::MODE_W-1:0] mode, logic [7:0] value);
         int unsigned extra;
         logic [29:0] m;
         logic [4:0]  sym;
         extra = in_data ? 0 : 1;
         case (mode)
            b32enc_pkg::MODE_PART: begin
               if (err != b32enc_pkg::STAT_OK || in_data) return;
               if (part_count + 9 > cap()) begin
                  err = b32enc_pkg::STAT_TOO_LONG;
                  return;
               end
               if (part_count >= PART_DEPTH) begin
                  err = b32enc_pkg::STAT_PART_FULL;
                  return;
               end
               part_bytes[part_count] = value;
               part_count++;
               length_count++;
               step({2'b00, value[7:5]});
               push(value, 1'b0, b32enc_pkg::STAT_OK);
            end
            b32enc_pkg::MODE_DATA: begin
               if (err != b32enc_pkg::STAT_OK) return;
               if (length_count + extra + 8 > cap()) begin
                  err = b32enc_pkg::STAT_TOO_LONG;
                  return;
               end
               if (value >= 32) begin
                  err = b32enc_pkg::STAT_BAD_VALUE;
                  return;
               end
               if (!in_data) open_data();
               step(value[4:0]);
               length_count++;
               push(charset[value[4:0]], 1'b0, b32enc_pkg::STAT_OK);
            end
            b32enc_pkg::MODE_FIN: begin
               if (err == b32enc_pkg::STAT_OK && length_count + extra + 7 > cap())
                  err = b32enc_pkg::STAT_TOO_LONG;
               if (err != b32enc_pkg::STAT_OK) begin
                  push(8'h00, 1'b1, err);
               end else begin
                  if (!in_data) open_data();
                  for (int i = 0; i < 6; i++) step(5'd0);
                  m = poly ^ 30'd1;
                  for (int i = 0; i < 6; i++) begin
                     sym = 5'(m >> (25 - 5 * i));
                     push(charset[sym], (i == 5), b32enc_pkg::STAT_OK);
                  end
               end
               restart();
            end
            default: ;   // unused mode, no effect
         endcase
      endfunction

      function void check_word(logic [7:0] ch, logic last, logic [1:0] st);
         enc_word_type w;
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected word: expected none, got char %h last %b status %0d",
                     $time, ch, last, st);
            mismatches++;
            return;
         end
         w = expected_words.pop_front();
         if (ch !== w.ch) begin
            $display("%0t: out_char mismatch: expected %h, got %h", $time, w.ch, ch);
            mismatches++;
         end
         if (last !== w.last) begin
            $display("%0t: last mismatch: expected %b, got %b", $time, w.last, last);
            mismatches++;
         end
         if (st !== w.st) begin
            $display("%0t: status mismatch: expected %0d, got %0d", $time, w.st, st);
            mismatches++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [b32enc_pkg::OUT_LIMIT_W-1:0] csr_wdata;
   bit   quiet;
   int   cycle_count;
   int   items_sent;

   bech32_scoreboard sb;

   b32enc_req_if req_if();
   b32enc_rsp_if rsp_if();

   bech32_string_encoder_unit #(
      .PART_MAX   (PART_DEPTH),
      .STRING_CAP (STR_CAP)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // clock
   always #1 clock = ~clock;

   // cycle limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // result side: random back-pressure
   always @(negedge clock) begin
      rsp_if.ready = quiet || ($urandom_range(99) >= IDLE_PCT);
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready)
         sb.check_word(rsp_if.out_char, rsp_if.last, rsp_if.status);
   end

   // -------------------------------------------------------------------------
   // Drivers; all called at a falling edge
   // -------------------------------------------------------------------------
   task automatic send_item(input logic [b32enc_pkg::MODE_W-1:0] mode,
                            input logic [7:0] value);
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid = 1'b1;
      req_if.mode  = mode;
      req_if.value = value;
      do @(posedge clock); while (!req_if.ready);
      sb.note_item(mode, value);
      @(negedge clock);
   endtask

   // hold off until every expected word is out and the block has settled
   task automatic drain();
      req_if.valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_limit(input logic [b32enc_pkg::OUT_LIMIT_W-1:0] v);
      drain();
      csr_we    = 1'b1;
      csr_wdata = v;
      @(negedge clock);
      csr_we = 1'b0;
      sb.set_limit(v);
   endtask

   // mostly well-formed strings, with some noise and broken values
   task automatic send_random_string();
      int nparts;
      int ndata;
      int r;
      nparts = ($urandom_range(99) < 3) ? $urandom_range(100, 130) : $urandom_range(0, 8);
      ndata  = ($urandom_range(99) < 5) ? $urandom_range(20, 60) : $urandom_range(0, 12);
      for (int i = 0; i < nparts; i++) begin
         if ($urandom_range(99) < 3) send_item(MODE_UNUSED, 8'($urandom_range(0, 255)));
         send_item(b32enc_pkg::MODE_PART, 8'($urandom_range(0, 255)));
         items_sent++;
      end
      for (int i = 0; i < ndata; i++) begin
         r = $urandom_range(99);
         if (r < 4) send_item(b32enc_pkg::MODE_PART, 8'($urandom_range(0, 255)));
         else if (r < 7) send_item(MODE_UNUSED, 8'($urandom_range(0, 255)));
         if ($urandom_range(99) < 4)
            send_item(b32enc_pkg::MODE_DATA, 8'($urandom_range(32, 255)));
         else
            send_item(b32enc_pkg::MODE_DATA, 8'($urandom_range(0, 31)));
         items_sent++;
      end
      send_item(b32enc_pkg::MODE_FIN, 8'($urandom_range(0, 255)));
      items_sent++;
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int limits[5];
      int strings_done;
      limits = '{1024, 40, 137, 1023, 20};

      sb           = new();
      clock        = 1'b0;
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_wdata    = '0;
      quiet        = 1'b0;
      cycle_count  = 0;
      items_sent   = 0;
      strings_done = 0;
      req_if.valid = 1'b0;
      req_if.mode  = b32enc_pkg::MODE_PART;
      req_if.value = '0;
      rsp_if.ready = 1'b0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: field extremes, all modes
      write_limit(11'd1024);
      send_item(b32enc_pkg::MODE_PART, 8'h00);
      send_item(b32enc_pkg::MODE_PART, 8'hff);
      send_item(b32enc_pkg::MODE_PART, "a");
      send_item(b32enc_pkg::MODE_DATA, 8'd0);
      send_item(b32enc_pkg::MODE_DATA, 8'd31);
      send_item(b32enc_pkg::MODE_FIN, 8'h00);
      // empty string
      send_item(b32enc_pkg::MODE_FIN, 8'hff);
      // data with no readable part
      send_item(b32enc_pkg::MODE_DATA, 8'd7);
      send_item(b32enc_pkg::MODE_FIN, 8'h00);
      // bad data value: sticky, later items silent
      send_item(b32enc_pkg::MODE_PART, "b");
      send_item(b32enc_pkg::MODE_DATA, 8'd32);
      send_item(b32enc_pkg::MODE_PART, "c");
      send_item(b32enc_pkg::MODE_DATA, 8'd1);
      send_item(b32enc_pkg::MODE_FIN, 8'h00);
      // part byte in data phase and unused mode are ignored
      send_item(b32enc_pkg::MODE_PART, "1");
      send_item(b32enc_pkg::MODE_DATA, 8'd3);
      send_item(b32enc_pkg::MODE_PART, "A");
      send_item(MODE_UNUSED, 8'h55);
      send_item(b32enc_pkg::MODE_FIN, 8'h00);
      send_item(b32enc_pkg::MODE_DATA, 8'd255);
      send_item(b32enc_pkg::MODE_FIN, 8'h00);

      // full part store walked, then one byte too many
      for (int i = 0; i < PART_DEPTH; i++)
         send_item(b32enc_pkg::MODE_PART, 8'($urandom_range(0, 255)));
      send_item(b32enc_pkg::MODE_FIN, 8'h00);
      for (int i = 0; i <= PART_DEPTH; i++)
         send_item(b32enc_pkg::MODE_PART, 8'($urandom_range(0, 255)));
      send_item(b32enc_pkg::MODE_FIN, 8'h00);

      // length boundary at a tight capacity
      write_limit(11'd9);
      send_item(b32enc_pkg::MODE_PART, "z");
      send_item(b32enc_pkg::MODE_PART, "y");
      send_item(b32enc_pkg::MODE_FIN, 8'h00);
      send_item(b32enc_pkg::MODE_FIN, 8'h00);
      send_item(b32enc_pkg::MODE_DATA, 8'd16);
      send_item(b32enc_pkg::MODE_FIN, 8'h00);

      // zero capacity: length error wins over bad value
      write_limit(11'd0);
      send_item(b32enc_pkg::MODE_DATA, 8'd40);
      send_item(b32enc_pkg::MODE_FIN, 8'h00);
      send_item(b32enc_pkg::MODE_FIN, 8'h00);
      send_item(b32enc_pkg::MODE_PART, 8'h20);
      send_item(b32enc_pkg::MODE_FIN, 8'h00);

      // random strings over several capacities
      for (int p = 0; p < 5; p++) begin
         write_limit(b32enc_pkg::OUT_LIMIT_W'(limits[p]));
         quiet = (p == 3);
         while (items_sent < (p + 1) * (RAND_ITEMS / 5)) begin
            send_random_string();
            strings_done++;
            if (strings_done % 7 == 0) drain();
         end
      end
      quiet = 1'b0;

      drain();
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         if (sb.pending() != 0)
            $display("%0t: %0d expected words never arrived", $time, sb.pending());
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
